@@ rtl/sda_pkg.sv @@
// Shared types and constants of the synaptic delay accumulator.
package sda_pkg;

    localparam int NEURONS     = 64;
    localparam int DELAY_SLOTS = 64;
    localparam int OFF_W       = 6;
    localparam int SLOT_W      = 6;
    localparam int ADDR_W      = OFF_W + SLOT_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam logic [SLOT_W-1:0] SLOT_MASK = 6'h3F;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_STEP  = 2'd1,
        FUNC_START = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_ISSUE,
        ST_ADD_CALC,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_ZERO
    } state_t;

    // Hand-off between the controller and the float adder.
    typedef struct packed {
        logic        valid;
        logic [31:0] bits;
    } fadd_res_t;

endpackage

@@ rtl/synaptic_delay_accumulator_core.sv @@
// Top level of the synaptic delay accumulator: controller, slot store and ports.
//
// The block keeps a ring of 64 single-precision slots for each of its
// neurons in one synchronous 4096-word store, addressed by neuron offset
// and slot. Items are taken one at a time. An add transaction whose target
// falls in this block's range occupies the block through a store read,
// the issue into the float adder and its five stages, with the write-back
// in the cycle the sum appears; one out of range or with an unused code
// is dropped on acceptance and leaves the block idle.
// An end-of-step transaction walks the neurons through the store and
// emits one result transaction per neuron, waiting while the last one is
// still pending, clearing each slot as it goes, then advances the head. A
// start transaction, and reset as well, runs a clearing pass over every
// word of the store; a start then emits one zero result per neuron.
// No input is accepted during a clearing pass, but configuration writes
// are taken at any time. The result register lets a new input be
// accepted while the last result still waits for the consumer.
module synaptic_delay_accumulator_core
    import sda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // delay[7:0], target_neuron[31:8], weight_bits[63:32]
    input  logic [1:0]  s_tuser,   // func[1:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // sum_bits[31:0], neuron_offset[37:32], zeros[39:38]
    output logic        m_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration register.
    logic [23:0] base_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {8'd0, base_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= 24'd0;
        else if (psel && penable && pwrite && (paddr[2] == 1'b0))
            base_reg <= pwdata[23:0];
    end

    // Input decode.
    logic [7:0]  in_delay;
    logic [23:0] in_target;
    logic [31:0] in_weight;
    logic [1:0]  in_func;
    logic        s_acc;
    logic        in_range;
    logic [23:0] in_diff;

    assign in_delay  = s_tdata[7:0];
    assign in_target = s_tdata[31:8];
    assign in_weight = s_tdata[63:32];
    assign in_func   = s_tuser;
    assign s_acc     = s_tvalid && s_tready;
    assign in_diff   = in_target - base_reg;
    assign in_range  = (in_target >= base_reg) && (in_diff < 24'(NEURONS));

    // Control state.
    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [OFF_W-1:0]    cnt_reg, cnt_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic                emit_reg, emit_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic [31:0]         weight_reg;

    // Store ports.
    logic [31:0]       store_mem [STORE_DEPTH];
    logic [31:0]       rdata_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [31:0]       mem_wdata;

    // Result register.
    logic              m_tvalid_reg;
    logic [31:0]       out_sum_reg, out_sum_next;
    logic [OFF_W-1:0]  out_off_reg;
    logic              out_last_reg;
    logic              out_load;

    // Float adder.
    logic      add_start;
    fadd_res_t add_res;

    sda_fadd u_fadd (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (add_start),
        .a        (rdata_reg),
        .b        (weight_reg),
        .res      (add_res)
    );

    assign s_tready = (state_reg == ST_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                    state_next = emit_reg ? ST_ZERO : ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    if ((in_func == FUNC_ADD) && in_range)
                        state_next = ST_ADD_RD;
                    else if (in_func == FUNC_STEP)
                        state_next = ST_EMIT_RD;
                    else if (in_func == FUNC_START)
                        state_next = ST_CLEAR;
                end
            end
            ST_ADD_RD:    state_next = ST_ADD_ISSUE;
            ST_ADD_ISSUE: state_next = ST_ADD_CALC;
            ST_ADD_CALC:
            begin
                if (add_res.valid)
                    state_next = ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                if (!m_tvalid_reg)
                    state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                state_next = (cnt_reg == OFF_W'(NEURONS - 1)) ? ST_IDLE : ST_EMIT_RD;
            end
            ST_ZERO:
            begin
                if (!m_tvalid_reg && (cnt_reg == OFF_W'(NEURONS - 1)))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the controller.
    always_comb
    begin
        mem_we       = 1'b0;
        mem_waddr    = addr_reg;
        mem_wdata    = 32'd0;
        mem_re       = 1'b0;
        mem_raddr    = addr_reg;
        out_load     = 1'b0;
        out_sum_next = 32'd0;
        add_start    = 1'b0;
        head_next    = head_reg;
        cnt_next     = cnt_reg;
        clr_next     = clr_reg;
        emit_next    = emit_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + ADDR_W'(1);
                cnt_next  = '0;
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                if (s_acc && (in_func == FUNC_START))
                begin
                    head_next = '0;
                    clr_next  = '0;
                    emit_next = 1'b1;
                end
            end
            ST_ADD_RD:
            begin
                mem_re = 1'b1;
            end
            ST_ADD_ISSUE:
            begin
                add_start = 1'b1;
            end
            ST_ADD_CALC:
            begin
                if (add_res.valid)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = add_res.bits;
                end
            end
            ST_EMIT_RD:
            begin
                mem_raddr = {cnt_reg, head_reg};
                mem_re    = !m_tvalid_reg;
            end
            ST_EMIT_LD:
            begin
                out_load     = 1'b1;
                out_sum_next = rdata_reg;
                mem_we       = 1'b1;
                mem_waddr    = {cnt_reg, head_reg};
                cnt_next     = cnt_reg + OFF_W'(1);
                if (cnt_reg == OFF_W'(NEURONS - 1))
                    head_next = (head_reg + SLOT_W'(1)) & SLOT_MASK;
            end
            ST_ZERO:
            begin
                if (!m_tvalid_reg)
                begin
                    out_load = 1'b1;
                    cnt_next = cnt_reg + OFF_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            head_reg  <= '0;
            cnt_reg   <= '0;
            clr_reg   <= '0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            emit_reg  <= (state_reg == ST_ZERO) ? 1'b0 : emit_next;
        end
    end

    // The item's store address and weight are captured on acceptance.
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            addr_reg   <= {in_diff[OFF_W-1:0], (head_reg + in_delay[SLOT_W-1:0]) & SLOT_MASK};
            weight_reg <= in_weight;
        end
    end

    // Slot store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= store_mem[mem_raddr];
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sum_reg  <= out_sum_next;
            out_off_reg  <= cnt_reg;
            out_last_reg <= (cnt_reg == OFF_W'(NEURONS - 1));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_off_reg, out_sum_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // A pending result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n) out_load |-> !m_tvalid_reg)
        else $error("result register overwritten");

    // The adder only finishes while the controller waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        add_res.valid |-> (state_reg == ST_ADD_CALC))
        else $error("adder result outside its wait state");

    // A start transaction resets the head.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && (in_func == FUNC_START)) |=> (head_reg == '0))
        else $error("head not reset by start");
`endif

endmodule

@@ rtl/sda_fadd.sv @@
// Five-stage IEEE single-precision adder with round to nearest even.
module sda_fadd
    import sda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output fadd_res_t   res
);

    logic [4:0] vld_reg;

    // Side band carried along the stages.
    logic [7:0]  s1_e_dly_reg;
    logic [7:0]  s3_e_reg;
    logic [27:0] s3_sum_reg;
    logic        sp2_reg, sp3_reg, sp4_reg;
    logic [31:0] spec2_reg, spec3_reg, spec4_reg;
    logic        sign3_reg, sign4_reg;

    // Stage 1: specials, swap and alignment.
    logic        s1_special_next, s1_special_reg;
    logic [31:0] s1_spec_next, s1_spec_reg;
    logic        s1_sl_next, s1_sl_reg, s1_ss_next, s1_ss_reg;
    logic [7:0]  s1_e_next, s1_e_reg;
    logic [26:0] s1_ml_next, s1_ml_reg, s1_ms_next, s1_ms_reg;

    always_comb
    begin
        logic        a_nan, b_nan, a_inf, b_inf, swap;
        logic [7:0]  ea, eb, el, es, d;
        logic [23:0] ma, mb;
        logic [4:0]  dsat;
        logic [53:0] sh;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        s1_special_next = a_nan || b_nan || a_inf || b_inf;
        if (a_nan)
            s1_spec_next = a | 32'h0040_0000;
        else if (b_nan)
            s1_spec_next = b | 32'h0040_0000;
        else if (a_inf && b_inf && (a[31] != b[31]))
            s1_spec_next = 32'hFFC0_0000;
        else if (a_inf)
            s1_spec_next = a;
        else
            s1_spec_next = b;
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        swap = (b[30:0] > a[30:0]);
        el = swap ? eb : ea;
        es = swap ? ea : eb;
        s1_sl_next = swap ? b[31] : a[31];
        s1_ss_next = swap ? a[31] : b[31];
        s1_ml_next = {(swap ? mb : ma), 3'b000};
        d = el - es;
        dsat = (d > 8'd27) ? 5'd27 : d[4:0];
        sh = {(swap ? ma : mb), 3'b000, 27'd0} >> dsat;
        s1_ms_next = {sh[53:28], sh[27] | (sh[26:0] != 27'd0)};
        s1_e_next = el;
    end

    // Stage 2: magnitude add or subtract.
    logic [27:0] s2_sum_next, s2_sum_reg;
    logic        s2_sign_next, s2_sign_reg;

    always_comb
    begin
        if (s1_sl_reg ^ s1_ss_reg)
            s2_sum_next = {1'b0, s1_ml_reg} - {1'b0, s1_ms_reg};
        else
            s2_sum_next = {1'b0, s1_ml_reg} + {1'b0, s1_ms_reg};
        // An exact cancellation gives +0.
        if ((s1_sl_reg ^ s1_ss_reg) && (s2_sum_next == 28'd0))
            s2_sign_next = 1'b0;
        else
            s2_sign_next = s1_sl_reg;
    end

    // Stage 3: leading-zero count.
    logic [4:0] s3_lz_next, s3_lz_reg;

    always_comb
    begin
        s3_lz_next = 5'd28;
        for (int i = 0; i < 28; i++)
        begin
            if (s2_sum_reg[i])
                s3_lz_next = 5'(27 - i);
        end
    end

    // Stage 4: normalize.
    logic [26:0] s4_m_next, s4_m_reg;
    logic [8:0]  s4_e_next, s4_e_reg;

    always_comb
    begin
        logic [4:0] lzm1, sh_amt;
        lzm1 = s3_lz_reg - 5'd1;
        sh_amt = ({3'd0, lzm1} > (s3_e_reg - 8'd1)) ? 5'(s3_e_reg - 8'd1) : lzm1;
        if (s3_sum_reg[27])
        begin
            s4_m_next = {s3_sum_reg[27:2], s3_sum_reg[1] | s3_sum_reg[0]};
            s4_e_next = {1'b0, s3_e_reg} + 9'd1;
        end
        else
        begin
            s4_m_next = s3_sum_reg[26:0] << sh_amt;
            s4_e_next = {1'b0, s3_e_reg} - {4'd0, sh_amt};
        end
    end

    // Stage 5: round and pack.
    logic [31:0] s5_res_next, s5_res_reg;

    always_comb
    begin
        logic [24:0] mr;
        logic [8:0]  er;
        logic        up;
        up = s4_m_reg[2] && (s4_m_reg[1] || s4_m_reg[0] || s4_m_reg[3]);
        mr = {1'b0, s4_m_reg[26:3]} + {24'd0, up};
        er = s4_e_reg;
        if (mr[24])
        begin
            mr = mr >> 1;
            er = er + 9'd1;
        end
        if (sp4_reg)
            s5_res_next = spec4_reg;
        else if (er >= 9'd255)
            s5_res_next = {sign4_reg, 8'hFF, 23'd0};
        else
            s5_res_next = {sign4_reg, (mr[23] ? er[7:0] : 8'd0), mr[22:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 5'd0;
        else
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        s1_special_reg <= s1_special_next;
        s1_spec_reg    <= s1_spec_next;
        s1_sl_reg      <= s1_sl_next;
        s1_ss_reg      <= s1_ss_next;
        s1_e_reg       <= s1_e_next;
        s1_ml_reg      <= s1_ml_next;
        s1_ms_reg      <= s1_ms_next;
        s2_sum_reg     <= s2_sum_next;
        s2_sign_reg    <= s2_sign_next;
        s1_e_dly_reg   <= s1_e_reg;
        sp2_reg        <= s1_special_reg;
        spec2_reg      <= s1_spec_reg;
        s3_lz_reg      <= s3_lz_next;
        s3_sum_reg     <= s2_sum_reg;
        s3_e_reg       <= s1_e_dly_reg;
        sp3_reg        <= sp2_reg;
        spec3_reg      <= spec2_reg;
        sign3_reg      <= s2_sign_reg;
        s4_m_reg       <= s4_m_next;
        s4_e_reg       <= s4_e_next;
        sp4_reg        <= sp3_reg;
        spec4_reg      <= spec3_reg;
        sign4_reg      <= sign3_reg;
        s5_res_reg     <= s5_res_next;
    end

    assign res.valid = vld_reg[4];
    assign res.bits  = s5_res_reg;

endmodule

@@ tb/synaptic_delay_accumulator_core_tb.sv @@
// Self-checking testbench for the synaptic delay accumulator core.
`timescale 1ns / 100ps

module synaptic_delay_accumulator_core_tb;
    import sda_pkg::*;

    // Function code 3 is not decoded by the block; it must be dropped silently.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [2:0] REG_NEURON_BASE = 3'd0;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 20;

    // One result transaction: the step sum of one neuron.
    typedef struct packed {
        logic [31:0] sum;
        logic [5:0]  off;
        logic        last;
    } neuron_sum_t;

    // One row of the directed table. When has_sum is set, the first result
    // of the run that the row causes must carry first_sum.
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  delay;
        logic [23:0] target;
        logic [31:0] weight;
        logic        has_sum;
        logic [31:0] first_sum;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // delay[7:0], target_neuron[31:8], weight_bits[63:32]
    logic [1:0]  s_tuser;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // sum_bits[31:0], neuron_offset[37:32], zeros[39:38]
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the block's state, advanced on every accepted transaction.
    logic [31:0] ring_slots [NEURONS][DELAY_SLOTS];
    logic [5:0]  ring_head;
    logic [23:0] base_shadow;

    neuron_sum_t pending_sums[$];
    int          errors;
    int          idle_cycles;
    int          rx_wait;
    bit          no_idle;

    synaptic_delay_accumulator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // IEEE single addition, round to nearest even. NaN handling follows the
    // usual x86 behavior: the first NaN operand is returned quieted, and
    // inf minus inf yields the default negative quiet NaN.
    function automatic logic [31:0] fp32_add(logic [31:0] x, logic [31:0] y);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] t;
        logic [49:0] ra;
        logic [49:0] rb;
        logic [50:0] r;
        logic [24:0] m;
        logic        stk;
        logic        inc;
        int          ea;
        int          eb;
        int          d;
        a = x;
        b = y;
        if (a[30:23] == 8'hFF && a[22:0] != 0)
            return a | 32'h0040_0000;
        if (b[30:23] == 8'hFF && b[22:0] != 0)
            return b | 32'h0040_0000;
        if (a[30:0] == 31'h7F80_0000 && b[30:0] == 31'h7F80_0000 && a[31] != b[31])
            return 32'hFFC0_0000;
        if (a[30:0] == 31'h7F80_0000)
            return a;
        if (b[30:0] == 31'h7F80_0000)
            return b;
        if (a[30:0] == 0 && b[30:0] == 0)
            return {a[31] & b[31], 31'h0};
        if (a[30:0] == 0)
            return b;
        if (b[30:0] == 0)
            return a;
        // Put the larger magnitude first so the result takes its sign.
        if (a[30:0] < b[30:0])
        begin
            t = a;
            a = b;
            b = t;
        end
        ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
        ra = {a[30:23] != 0, a[22:0], 26'h0};
        rb = {b[30:23] != 0, b[22:0], 26'h0};
        d = ea - eb;
        if (d > 49)
            rb = 50'(rb != 0);
        else if (d > 0)
        begin
            stk = |(rb & ((50'd1 << d) - 50'd1));
            rb = (rb >> d) | 50'(stk);
        end
        r = (a[31] == b[31]) ? ({1'b0, ra} + {1'b0, rb}) : ({1'b0, ra} - {1'b0, rb});
        if (r == 0)
            return 32'h0;
        if (r[50])
        begin
            r = (r >> 1) | 51'(r[0]);
            ea++;
        end
        while (!r[49] && ea > 1)
        begin
            r = r << 1;
            ea--;
        end
        inc = r[25] && ((|r[24:0]) || r[26]);
        m = {1'b0, r[49:26]} + 25'(inc);
        if (m[24])
        begin
            m = m >> 1;
            ea++;
        end
        if (ea >= 255)
            return {a[31], 8'hFF, 23'h0};
        return {a[31], (m[23] ? 8'(ea) : 8'h0), m[22:0]};
    endfunction

    // Advance the shadow state by one accepted transaction and queue the
    // neuron sums it must produce.
    task automatic predict_sums(input logic [1:0] func, input logic [7:0] delay,
                                input logic [23:0] target, input logic [31:0] weight,
                                input logic has_sum, input logic [31:0] first_sum);
        neuron_sum_t ns;
        logic [5:0]  slot;
        logic [5:0]  off;
        int          n;
        if (func == FUNC_ADD)
        begin
            if ({8'h0, target} >= {8'h0, base_shadow} &&
                {8'h0, target} < {8'h0, base_shadow} + 32'(NEURONS))
            begin
                off = 6'(target - base_shadow);
                slot = ring_head + delay[5:0];
                ring_slots[off][slot] = fp32_add(ring_slots[off][slot], weight);
            end
        end
        else if (func == FUNC_STEP || func == FUNC_START)
        begin
            if (func == FUNC_START)
            begin
                foreach (ring_slots[i, j])
                    ring_slots[i][j] = 32'h0;
                ring_head = 6'd0;
            end
            for (n = 0; n < NEURONS; n++)
            begin
                ns.sum = ring_slots[n][ring_head];
                if (n == 0 && has_sum)
                    ns.sum = first_sum;
                ns.off = 6'(n);
                ns.last = (n == NEURONS - 1);
                pending_sums.push_back(ns);
                ring_slots[n][ring_head] = 32'h0;
            end
            if (func == FUNC_STEP)
                ring_head = ring_head + 6'd1;
        end
    endtask

    // Present one item after a random gap (none while no_idle is set) and hold it until it is taken.
    task automatic send_item(input logic [1:0] func, input logic [7:0] delay,
                             input logic [23:0] target, input logic [31:0] weight,
                             input logic has_sum, input logic [31:0] first_sum);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {weight, target, delay};
        do
            @(posedge clk);
        while (!s_tready);
        predict_sums(func, delay, target, weight, has_sum, first_sum);
    endtask

    // Wait for every queued sum, then let any add still in flight settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge that closes the access cycle.
    task automatic write_base(input logic [23:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_NEURON_BASE;
        pwdata  <= {8'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        base_shadow = value;
    endtask

    function automatic logic [31:0] pick_weight();
        logic [31:0] w;
        logic        sgn;
        sgn = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            7:
            begin
                case ($urandom_range(0, 5))
                    0: w = 32'h7F80_0000;
                    1: w = 32'hFF80_0000;
                    2: w = {sgn, 8'hFF, 23'($urandom) | 23'h1};
                    3: w = {sgn, 31'h0};
                    4: w = 32'h7F7F_FFFF;
                    default: w = 32'hFF7F_FFFF;
                endcase
            end
            6: w = $urandom;
            8: w = {sgn, 8'h00, 23'($urandom)};
            9: w = {sgn, 8'($urandom_range(250, 254)), 23'($urandom)};
            default: w = {sgn, 8'($urandom_range(118, 136)), 23'($urandom)};
        endcase
        return w;
    endfunction

    // Result side: compare each accepted sum with the oldest expectation and
    // draw a fresh stall for the next one.
    always @(posedge clk)
    begin
        neuron_sum_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_sums.size() == 0)
            begin
                $display("%0t: unexpected result sum=%h off=%0d last=%b",
                         $time, m_tdata[31:0], m_tdata[37:32], m_tlast);
                errors++;
            end
            else
            begin
                want = pending_sums.pop_front();
                if (m_tdata[31:0] !== want.sum)
                begin
                    $display("%0t: sum mismatch off=%0d expected %h actual %h",
                             $time, want.off, want.sum, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[37:32] !== want.off || m_tdata[39:38] !== 2'b00)
                begin
                    $display("%0t: offset mismatch expected %0d actual %0d",
                             $time, want.off, m_tdata[39:32]);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last mismatch off=%0d expected %b actual %b",
                             $time, want.off, want.last, m_tlast);
                    errors++;
                end
            end
            rx_wait = no_idle ? 0 : $urandom_range(0, 10);
        end
        else if (rx_wait > 0)
            rx_wait--;
        m_tready <= (rx_wait == 0);
    end

    // Watchdog: the clearing pass is the longest quiet stretch a correct
    // block shows, so the limit sits several times above it.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("synaptic_delay_accumulator_core_tb: FAIL");
            $finish;
        end
    end

    stim_row_t   directed [$];
    logic [23:0] bases [5];
    logic [1:0]  func;
    logic [7:0]  delay;
    logic [23:0] target;
    int          ph;
    int          k;
    int          roll;

    initial
    begin
        errors      = 0;
        idle_cycles = 0;
        rx_wait     = 0;
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 64'h0;
        s_tuser     = FUNC_ADD;
        m_tready    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = REG_NEURON_BASE;
        pwdata      = 32'h0;
        base_shadow = 24'h0;
        ring_head   = 6'd0;
        foreach (ring_slots[i, j])
            ring_slots[i][j] = 32'h0;

        // Directed part: start, an empty step, sums through the delay wrap,
        // overflow to infinity, out-of-range targets, the unused code, then
        // NaN, inf minus inf, subnormals, signed zeros and cancellation.
        directed = '{
            '{FUNC_START,  8'd0,   24'd0,       32'h0000_0000, 1'b1, 32'h0000_0000},
            '{FUNC_STEP,   8'd0,   24'd0,       32'h0000_0000, 1'b1, 32'h0000_0000},
            '{FUNC_ADD,    8'd0,   24'd0,       32'h3F80_0000, 1'b0, 32'h0},
            '{FUNC_ADD,    8'd0,   24'd0,       32'h4000_0000, 1'b0, 32'h0},
            '{FUNC_ADD,    8'd64,  24'd0,       32'h4040_0000, 1'b0, 32'h0},
            '{FUNC_ADD,    8'd1,   24'd63,      32'h7F7F_FFFF, 1'b0, 32'h0},
            '{FUNC_ADD,    8'd1,   24'd63,      32'h7F7F_FFFF, 1'b0, 32'h0},
            '{FUNC_ADD,    8'd1,   24'd64,      32'h3F80_0000, 1'b0, 32'h0},
            '{FUNC_ADD,    8'd1,   24'hFF_FFFF, 32'h3F80_0000, 1'b0, 32'h0},
            '{FUNC_UNUSED, 8'hFF,  24'hFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
            '{FUNC_STEP,   8'd0,   24'd0,       32'h0000_0000, 1'b1, 32'h40C0_0000},
            '{FUNC_ADD,    8'd255, 24'd1,       32'h7FC0_0001, 1'b0, 32'h0},
            '{FUNC_ADD,    8'd128, 24'd2,       32'h7F80_0000, 1'b0, 32'h0},
            '{FUNC_ADD,    8'd128, 24'd2,       32'hFF80_0000, 1'b0, 32'h0},
            '{FUNC_ADD,    8'd0,   24'd3,       32'h0000_0001, 1'b0, 32'h0},
            '{FUNC_ADD,    8'd0,   24'd3,       32'h807F_FFFF, 1'b0, 32'h0},
            '{FUNC_ADD,    8'd0,   24'd4,       32'h8000_0000, 1'b0, 32'h0},
            '{FUNC_ADD,    8'd0,   24'd5,       32'h3F80_0000, 1'b0, 32'h0},
            '{FUNC_ADD,    8'd0,   24'd5,       32'hBF80_0000, 1'b0, 32'h0},
            '{FUNC_ADD,    8'd0,   24'd6,       32'h0080_0000, 1'b0, 32'h0},
            '{FUNC_ADD,    8'd0,   24'd6,       32'h807F_FFFF, 1'b0, 32'h0},
            '{FUNC_STEP,   8'd0,   24'd0,       32'h0000_0000, 1'b0, 32'h0},
            '{FUNC_STEP,   8'd0,   24'd0,       32'h0000_0000, 1'b0, 32'h0},
            '{FUNC_START,  8'd0,   24'd0,       32'h0000_0000, 1'b1, 32'h0000_0000}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_item(directed[i].func, directed[i].delay, directed[i].target,
                      directed[i].weight, directed[i].has_sum, directed[i].first_sum);
        drain_results();

        // Random phases, each under its own neuron base. The drain before
        // each register write also makes the sender hold off until every
        // expected sum has come back.
        bases = '{24'hFF_FFC0, 24'hFF_FFFF, 24'h00_0000, 24'h0, 24'h5A_A5C3};
        bases[3] = 24'($urandom);
        for (ph = 0; ph < 5; ph++)
        begin
            write_base(bases[ph]);
            no_idle = (ph == 2);
            for (k = 0; k < 64; k++)
            begin
                roll = $urandom_range(0, 99);
                delay = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
                if (roll < 12)
                    func = FUNC_STEP;
                else if (roll < 13)
                    func = FUNC_START;
                else if (roll < 16)
                    func = FUNC_UNUSED;
                else
                    func = FUNC_ADD;
                if (roll >= 16 && roll < 24)
                    target = 24'($urandom);
                else
                    target = base_shadow + 24'($urandom_range(0, NEURONS - 1));
                send_item(func, delay, target, pick_weight(), 1'b0, 32'h0);
            end
            send_item(FUNC_STEP, 8'($urandom), 24'($urandom), $urandom, 1'b0, 32'h0);
            drain_results();
        end

        if (errors == 0)
            $display("synaptic_delay_accumulator_core_tb: PASS");
        else
            $display("synaptic_delay_accumulator_core_tb: FAIL");
        $finish;
    end

endmodule
